// File: design/gac_pkg.sv
// shared types, register codes and constants for the gamepad axis conditioner
package gac_pkg;

  localparam int AXIS_W = 16;
  localparam int DPAD_W = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W = 104;
  localparam int OUT_DATA_W = 104;

  // d-pad bit positions
  localparam int DPAD_UP = 0;
  localparam int DPAD_DOWN = 1;
  localparam int DPAD_LEFT = 2;
  localparam int DPAD_RIGHT = 3;

  // centered mode mask bit positions
  localparam int GRP_LS = 0;
  localparam int GRP_RS = 1;
  localparam int GRP_LT = 2;
  localparam int GRP_RT = 3;

  localparam logic [AXIS_W-1:0] DZ_RESET = 16'd10000;
  localparam logic [3:0] CENTERED_RESET = 4'd3;
  localparam logic signed [AXIS_W-1:0] REMAP_OFFSET = 16'sd16384;
  localparam logic [14:0] TAN_22_5_Q16 = 15'd27146;
  // 16384 squared, radius at which the stick starts to press d-pad bits
  localparam logic [32:0] DPAD_RADIUS_SQ = 33'd268435456;

  // stick positions driven by the d-pad
  localparam logic signed [AXIS_W-1:0] DIAG_POS = 16'sd23169;
  localparam logic signed [AXIS_W-1:0] DIAG_NEG = -16'sd23170;
  localparam logic signed [AXIS_W-1:0] FULL_POS = 16'sd32767;
  localparam logic signed [AXIS_W-1:0] FULL_NEG = 16'sh8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LS_DZ     = 3'd0,
    REG_RS_DZ     = 3'd1,
    REG_LT_DZ     = 3'd2,
    REG_RT_DZ     = 3'd3,
    REG_CENTERED  = 3'd4,
    REG_A2D_EN    = 3'd5,
    REG_D2A_EN    = 3'd6,
    REG_REL_CLEAR = 3'd7
  } gac_reg_t;

  typedef struct packed {
    logic [AXIS_W-1:0] ls_dz;
    logic [AXIS_W-1:0] rs_dz;
    logic [AXIS_W-1:0] lt_dz;
    logic [AXIS_W-1:0] rt_dz;
    logic [3:0]        centered;
    logic              a2d_en;
    logic              d2a_en;
    logic              rel_clear;
  } gac_cfg_t;

  typedef struct packed {
    logic a2d_en;
    logic d2a_en;
    logic rel_clear;
    logic radius_hit;
  } gac_dpad_ctl_t;

endpackage

// File: design/gac_dpad.sv
// analog to d-pad sector decode and d-pad to stick mapping
module gac_dpad (
  input  gac_pkg::gac_dpad_ctl_t ctl,
  input  logic [3:0]             dpad_i,
  input  logic signed [15:0]     x_i,
  input  logic signed [15:0]     y_i,
  input  logic [30:0]            ax_i,
  input  logic [30:0]            ay_i,
  output logic [3:0]             dpad_o,
  output logic signed [15:0]     x_o,
  output logic signed [15:0]     y_o
);
  import gac_pkg::*;

  logic signed [16:0] pos_x;
  logic signed [16:0] neg_x;
  logic signed [16:0] pos_y;
  logic signed [16:0] neg_y;
  logic signed [32:0] ax_s;
  logic signed [32:0] ay_s;
  logic [3:0]         sector;
  logic [3:0]         dpad_all;
  logic               up;
  logic               down;
  logic               left;
  logic               right;

  // screen y points down, so up is negative y
  assign pos_x = {x_i[15], x_i};
  assign neg_x = -pos_x;
  assign neg_y = {y_i[15], y_i};
  assign pos_y = -neg_y;
  assign ax_s  = $signed({2'b00, ax_i});
  assign ay_s  = $signed({2'b00, ay_i});

  // 135 degree sectors, diagonals press two bits
  always_comb begin
    sector             = '0;
    sector[DPAD_UP]    = $signed({pos_y, 16'h0000}) > ax_s;
    sector[DPAD_DOWN]  = $signed({neg_y, 16'h0000}) > ax_s;
    sector[DPAD_LEFT]  = $signed({neg_x, 16'h0000}) > ay_s;
    sector[DPAD_RIGHT] = $signed({pos_x, 16'h0000}) > ay_s;
  end

  assign dpad_all = dpad_i | ((ctl.a2d_en && ctl.radius_hit) ? sector : 4'b0000);
  assign dpad_o   = dpad_all;

  assign up    = dpad_all[DPAD_UP];
  assign down  = dpad_all[DPAD_DOWN];
  assign left  = dpad_all[DPAD_LEFT];
  assign right = dpad_all[DPAD_RIGHT];

  // priority: diagonals first, then right, up, left, down
  always_comb begin
    x_o = x_i;
    y_o = y_i;
    if (ctl.d2a_en) begin
      if (up && right) begin
        x_o = DIAG_POS;
        y_o = DIAG_NEG;
      end else if (up && left) begin
        x_o = DIAG_NEG;
        y_o = DIAG_NEG;
      end else if (down && left) begin
        x_o = DIAG_NEG;
        y_o = DIAG_POS;
      end else if (down && right) begin
        x_o = DIAG_POS;
        y_o = DIAG_POS;
      end else if (right) begin
        x_o = FULL_POS;
        y_o = '0;
      end else if (up) begin
        x_o = '0;
        y_o = FULL_NEG;
      end else if (left) begin
        x_o = FULL_NEG;
        y_o = '0;
      end else if (down) begin
        x_o = '0;
        y_o = FULL_POS;
      end else if (ctl.rel_clear) begin
        x_o = '0;
        y_o = '0;
      end
    end
  end

endmodule

// File: design/gamepad_axis_conditioner_top.sv
// top level of the gamepad axis conditioner: remap, radial deadzone and d-pad mapping
// pipeline stages: input, product and result, from input request to result request
// throughput: one sample per cycle; every stage moves on when the one after it is free
// the result register holds its request under back-pressure while earlier stages keep filling
// reset: rst_n synchronous, active low; empties the pipeline and loads the register defaults
// configuration writes are taken at once (cfg_ready is always high) and reach samples still
// held in the input or product stage
module gamepad_axis_conditioner_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // input samples
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // left_x_in, left_y_in, right_x_in, right_y_in, left_trigger_in,
  // right_trigger_in (16 bits each), dpad_in (4), zero pad (4)
  input  logic [gac_pkg::IN_DATA_W-1:0]       in_tdata,
  // conditioned samples
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // left_x_out, left_y_out, right_x_out, right_y_out, left_trigger_out,
  // right_trigger_out (16 bits each), left_trigger_digital (1),
  // right_trigger_digital (1), dpad_out (4), zero pad (2)
  output logic [gac_pkg::OUT_DATA_W-1:0]      out_tdata,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gac_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gac_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import gac_pkg::*;

  // v/2 truncated toward zero, then moved up by 16384
  function automatic logic signed [15:0] remap_half(input logic signed [15:0] v);
    logic signed [16:0] t;
    t = $signed({v[15], v}) + $signed({16'h0000, v[15]});
    return $signed(t[16:1]) + REMAP_OFFSET;
  endfunction

  // magnitude of a signed axis; -32768 gives 32768
  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    return v[15] ? (~v + 16'd1) : v;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  gac_cfg_t cfg_r;
  gac_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (gac_reg_t'(cfg_index))
        REG_LS_DZ:     cfg_nxt.ls_dz     = cfg_data;
        REG_RS_DZ:     cfg_nxt.rs_dz     = cfg_data;
        REG_LT_DZ:     cfg_nxt.lt_dz     = cfg_data;
        REG_RT_DZ:     cfg_nxt.rt_dz     = cfg_data;
        REG_CENTERED:  cfg_nxt.centered  = cfg_data[3:0];
        REG_A2D_EN:    cfg_nxt.a2d_en    = cfg_data[0];
        REG_D2A_EN:    cfg_nxt.d2a_en    = cfg_data[0];
        REG_REL_CLEAR: cfg_nxt.rel_clear = cfg_data[0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ls_dz     <= DZ_RESET;
      cfg_r.rs_dz     <= DZ_RESET;
      cfg_r.lt_dz     <= DZ_RESET;
      cfg_r.rt_dz     <= DZ_RESET;
      cfg_r.centered  <= CENTERED_RESET;
      cfg_r.a2d_en    <= 1'b1;
      cfg_r.d2a_en    <= 1'b0;
      cfg_r.rel_clear <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline flow control
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r;
  logic v1_nxt, v2_nxt, v3_nxt;
  logic s1_free, s2_free, s3_free;
  logic in_fire;

  // a stage may load when it is empty or its contents move on this cycle
  assign s3_free   = !v3_r || out_tready;
  assign s2_free   = !v2_r || s3_free;
  assign s1_free   = !v1_r || s2_free;
  assign in_tready = s1_free;
  assign in_fire   = in_tvalid && s1_free;

  assign v1_nxt = s1_free ? in_tvalid : v1_r;
  assign v2_nxt = s2_free ? v1_r : v2_r;
  assign v3_nxt = s3_free ? v2_r : v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: input register
  // ---------------------------------------------------------------------------
  logic signed [15:0] s1_lx_r, s1_ly_r, s1_rx_r, s1_ry_r, s1_lt_r, s1_rt_r;
  logic [3:0]         s1_dpad_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_lx_r   <= in_tdata[15:0];
      s1_ly_r   <= in_tdata[31:16];
      s1_rx_r   <= in_tdata[47:32];
      s1_ry_r   <= in_tdata[63:48];
      s1_lt_r   <= in_tdata[79:64];
      s1_rt_r   <= in_tdata[95:80];
      s1_dpad_r <= in_tdata[99:96];
    end
  end

  // remap of non-centred groups, then squares and sector products
  logic signed [15:0] rm_lx, rm_ly, rm_rx, rm_ry, rm_lt, rm_rt;
  logic [15:0]        mg_lx, mg_ly, mg_rx, mg_ry, mg_lt, mg_rt;

  assign rm_lx = cfg_r.centered[GRP_LS] ? s1_lx_r : remap_half(s1_lx_r);
  assign rm_ly = cfg_r.centered[GRP_LS] ? s1_ly_r : remap_half(s1_ly_r);
  assign rm_rx = cfg_r.centered[GRP_RS] ? s1_rx_r : remap_half(s1_rx_r);
  assign rm_ry = cfg_r.centered[GRP_RS] ? s1_ry_r : remap_half(s1_ry_r);
  assign rm_lt = cfg_r.centered[GRP_LT] ? s1_lt_r : remap_half(s1_lt_r);
  assign rm_rt = cfg_r.centered[GRP_RT] ? s1_rt_r : remap_half(s1_rt_r);

  assign mg_lx = mag16(rm_lx);
  assign mg_ly = mag16(rm_ly);
  assign mg_rx = mag16(rm_rx);
  assign mg_ry = mag16(rm_ry);
  assign mg_lt = mag16(rm_lt);
  assign mg_rt = mag16(rm_rt);

  // squares of magnitudes up to 32768 stay within 31 bits
  logic [30:0] sq_lx_nxt, sq_ly_nxt, sq_rx_nxt, sq_ry_nxt, sq_lt_nxt, sq_rt_nxt;
  logic [31:0] dz_ls_nxt, dz_rs_nxt, dz_lt_nxt, dz_rt_nxt;
  logic [30:0] ax_nxt, ay_nxt;

  assign sq_lx_nxt = {15'd0, mg_lx} * {15'd0, mg_lx};
  assign sq_ly_nxt = {15'd0, mg_ly} * {15'd0, mg_ly};
  assign sq_rx_nxt = {15'd0, mg_rx} * {15'd0, mg_rx};
  assign sq_ry_nxt = {15'd0, mg_ry} * {15'd0, mg_ry};
  assign sq_lt_nxt = {15'd0, mg_lt} * {15'd0, mg_lt};
  assign sq_rt_nxt = {15'd0, mg_rt} * {15'd0, mg_rt};
  assign dz_ls_nxt = {16'd0, cfg_r.ls_dz} * {16'd0, cfg_r.ls_dz};
  assign dz_rs_nxt = {16'd0, cfg_r.rs_dz} * {16'd0, cfg_r.rs_dz};
  assign dz_lt_nxt = {16'd0, cfg_r.lt_dz} * {16'd0, cfg_r.lt_dz};
  assign dz_rt_nxt = {16'd0, cfg_r.rt_dz} * {16'd0, cfg_r.rt_dz};
  // taken before the deadzone; a zeroed stick never reaches the d-pad radius anyway
  assign ax_nxt    = {15'd0, mg_lx} * {16'd0, TAN_22_5_Q16};
  assign ay_nxt    = {15'd0, mg_ly} * {16'd0, TAN_22_5_Q16};

  // ---------------------------------------------------------------------------
  // stage 2: product register
  // ---------------------------------------------------------------------------
  logic signed [15:0] s2_lx_r, s2_ly_r, s2_rx_r, s2_ry_r, s2_lt_r, s2_rt_r;
  logic [3:0]         s2_dpad_r;
  logic [30:0]        sq_lx_r, sq_ly_r, sq_rx_r, sq_ry_r, sq_lt_r, sq_rt_r;
  logic [31:0]        dz_ls_r, dz_rs_r, dz_lt_r, dz_rt_r;
  logic [30:0]        ax_r, ay_r;

  always_ff @(posedge clk) begin
    if (v1_r && s2_free) begin
      s2_lx_r   <= rm_lx;
      s2_ly_r   <= rm_ly;
      s2_rx_r   <= rm_rx;
      s2_ry_r   <= rm_ry;
      s2_lt_r   <= rm_lt;
      s2_rt_r   <= rm_rt;
      s2_dpad_r <= s1_dpad_r;
      sq_lx_r   <= sq_lx_nxt;
      sq_ly_r   <= sq_ly_nxt;
      sq_rx_r   <= sq_rx_nxt;
      sq_ry_r   <= sq_ry_nxt;
      sq_lt_r   <= sq_lt_nxt;
      sq_rt_r   <= sq_rt_nxt;
      dz_ls_r   <= dz_ls_nxt;
      dz_rs_r   <= dz_rs_nxt;
      dz_lt_r   <= dz_lt_nxt;
      dz_rt_r   <= dz_rt_nxt;
      ax_r      <= ax_nxt;
      ay_r      <= ay_nxt;
    end
  end

  // deadzone compares: stick radius squared, trigger as the point (v, v)
  logic [32:0] l_sum, r_sum;
  logic        l_pass, r_pass, lt_pass, rt_pass;

  assign l_sum   = {2'b00, sq_lx_r} + {2'b00, sq_ly_r};
  assign r_sum   = {2'b00, sq_rx_r} + {2'b00, sq_ry_r};
  assign l_pass  = l_sum > {1'b0, dz_ls_r};
  assign r_pass  = r_sum > {1'b0, dz_rs_r};
  assign lt_pass = {1'b0, sq_lt_r, 1'b0} > {1'b0, dz_lt_r};
  assign rt_pass = {1'b0, sq_rt_r, 1'b0} > {1'b0, dz_rt_r};

  logic signed [15:0] dz_lx, dz_ly;
  gac_dpad_ctl_t      dpad_ctl;
  logic [3:0]         dpad_nxt;
  logic signed [15:0] lx_nxt, ly_nxt;

  assign dz_lx = l_pass ? s2_lx_r : '0;
  assign dz_ly = l_pass ? s2_ly_r : '0;

  assign dpad_ctl.a2d_en     = cfg_r.a2d_en;
  assign dpad_ctl.d2a_en     = cfg_r.d2a_en;
  assign dpad_ctl.rel_clear  = cfg_r.rel_clear;
  assign dpad_ctl.radius_hit = l_pass && (l_sum > DPAD_RADIUS_SQ);

  gac_dpad u_dpad (
    .ctl    (dpad_ctl),
    .dpad_i (s2_dpad_r),
    .x_i    (dz_lx),
    .y_i    (dz_ly),
    .ax_i   (ax_r),
    .ay_i   (ay_r),
    .dpad_o (dpad_nxt),
    .x_o    (lx_nxt),
    .y_o    (ly_nxt)
  );

  // ---------------------------------------------------------------------------
  // stage 3: result register
  // ---------------------------------------------------------------------------
  logic signed [15:0] o_lx_r, o_ly_r, o_rx_r, o_ry_r, o_lt_r, o_rt_r;
  logic               o_ldig_r, o_rdig_r;
  logic [3:0]         o_dpad_r;

  always_ff @(posedge clk) begin
    if (v2_r && s3_free) begin
      o_lx_r   <= lx_nxt;
      o_ly_r   <= ly_nxt;
      o_rx_r   <= r_pass ? s2_rx_r : '0;
      o_ry_r   <= r_pass ? s2_ry_r : '0;
      o_lt_r   <= lt_pass ? s2_lt_r : '0;
      o_rt_r   <= rt_pass ? s2_rt_r : '0;
      o_ldig_r <= lt_pass;
      o_rdig_r <= rt_pass;
      o_dpad_r <= dpad_nxt;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = {2'b00, o_dpad_r, o_rdig_r, o_ldig_r,
                       o_rt_r, o_lt_r, o_ry_r, o_rx_r, o_ly_r, o_lx_r};

endmodule
